>>> rtl/dpa_pkg.sv
// Shared types and constants for the duty-cycled particle averager.
// No dependencies; every other file in rtl/ imports this package.
`timescale 1ns / 1ps

package dpa_pkg;

   localparam int LANES      = 3;
   localparam int RAW_W      = 16;
   localparam int SUM_W      = 32;
   localparam int FRAMES_W   = 16;
   localparam int WAKE_W     = 27;
   localparam int INTERVAL_W = 20;
   localparam int OUT_TIME_W = 32;
   localparam int COUNT_W    = 32;

   localparam logic [FRAMES_W-1:0]   FRAMES_MAX   = '1;
   localparam logic [WAKE_W-1:0]     WAKE_RST     = WAKE_W'(60000);
   localparam logic [INTERVAL_W-1:0] WARMUP_RST   = INTERVAL_W'(30000);
   localparam logic [INTERVAL_W-1:0] WINDOW_RST   = INTERVAL_W'(10000);
   localparam logic [INTERVAL_W-1:0] STALE_TO_RST = INTERVAL_W'(10000);

   // register map, one 32-bit word per register
   typedef enum logic [1:0] {
      CSR_WAKE_PERIOD = 2'd0,
      CSR_WARMUP      = 2'd1,
      CSR_WINDOW      = 2'd2,
      CSR_STALE_TO    = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_APPLY,
      ST_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic [WAKE_W-1:0]     wake_period;
      logic [INTERVAL_W-1:0] warmup;
      logic [INTERVAL_W-1:0] window;
      logic [INTERVAL_W-1:0] stale_to;
   } cfg_type;

   // sequencer commands to every lane
   typedef struct packed {
      logic                capture;
      logic                clear;
      logic                acc;
      logic                load;
      logic                step;
      logic                commit;
      logic [FRAMES_W-1:0] divisor;
   } lane_ctl_type;

   typedef struct packed {
      logic                  out_load;
      logic                  asleep;
      logic                  have_reading;
      logic                  new_mean;
      logic                  stale;
      logic [OUT_TIME_W-1:0] mean_time;
      logic [COUNT_W-1:0]    count;
   } status_type;

endpackage

>>> rtl/dpa_lane.sv
// One measurement lane: latches a raw reading, accumulates the window sum and
// divides it by the frame count with a bit-serial restoring divider.
// Depends on dpa_pkg.
`timescale 1ns / 1ps

module dpa_lane (
   input  logic                               clock,
   input  logic                               reset,
   input  dpa_pkg::lane_ctl_type              ctl,
   input  logic [dpa_pkg::RAW_W-1:0]          raw,
   output logic [dpa_pkg::RAW_W-1:0]          mean
);
   import dpa_pkg::*;

   logic [RAW_W-1:0] raw_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [RAW_W-1:0] rem_ff;
   logic [RAW_W-1:0] quo_ff;
   logic [RAW_W-1:0] mean_ff;

   logic [RAW_W:0]   shifted;
   logic [RAW_W:0]   diff;
   logic             ge;
   logic [RAW_W-1:0] rem_in;
   logic [RAW_W-1:0] quo_in;

   // sum < frames * 2^16, so the upper half is already below the divisor and
   // sixteen quotient bits cover the whole result
   always_comb begin
      shifted = {rem_ff, quo_ff[RAW_W-1]};
      diff    = shifted - {1'b0, ctl.divisor};
      ge      = shifted >= {1'b0, ctl.divisor};
      rem_in  = ge ? diff[RAW_W-1:0] : shifted[RAW_W-1:0];
      quo_in  = {quo_ff[RAW_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         raw_ff <= raw;
      end
      if (ctl.load) begin
         rem_ff <= sum_ff[SUM_W-1:RAW_W];
         quo_ff <= sum_ff[RAW_W-1:0];
      end else if (ctl.step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         mean_ff <= '0;
      end else begin
         if (ctl.clear) begin
            sum_ff <= '0;
         end else if (ctl.acc) begin
            sum_ff <= sum_ff + SUM_W'(raw_ff);
         end
         if (ctl.commit) begin
            mean_ff <= quo_in;
         end
      end
   end

   assign mean = mean_ff;

endmodule

>>> rtl/dpa_ctrl.sv
// Duty-cycle sequencer: wake, warm-up, window and stale timing, frame count,
// publication bookkeeping and the lane command stream.
// Depends on dpa_pkg.
`timescale 1ns / 1ps

module dpa_ctrl #(
   parameter int TIME_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dpa_pkg::cfg_type              cfg,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [31:0]                   req_now,
   input  logic                          req_frame,
   input  logic                          rsp_free,
   output dpa_pkg::lane_ctl_type         lane_ctl,
   output dpa_pkg::status_type           status
);
   import dpa_pkg::*;

   localparam int CW    = (TIME_WIDTH > WAKE_W) ? TIME_WIDTH : WAKE_W;
   localparam int CNT_W = $clog2(RAW_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RAW_W - 1);

   state_type state_ff, state_in;

   logic [TIME_WIDTH-1:0] now_ff, cycle_ff, wake_ff, last_ff, pub_time_ff;
   logic [TIME_WIDTH-1:0] cycle_in, wake_in, last_in, pub_time_in;
   logic                  frame_ff;
   logic                  wake_hit_ff, warm_el_ff, end_el_ff, stale_el_ff;
   logic                  wake_hit_in, warm_el_in, end_el_in, stale_el_in;
   logic                  asleep_ff, warming_ff, valid_ff, new_mean_ff, stale_ff;
   logic                  asleep_in, warming_in, valid_in, new_mean_in, stale_in;
   logic [FRAMES_W-1:0]   frames_ff, frames_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;

   logic [TIME_WIDTH+31:0]   now_ext;
   logic [TIME_WIDTH+31:0]   pub_ext;
   logic                     accept;
   logic [TIME_WIDTH-1:0]    el_cycle, el_wake, el_last;
   logic [INTERVAL_W:0]      warm_end;
   logic                     awake, warming_cur, warm_eff, acc, finish, publish;

   assign accept  = req_valid && req_ready;
   assign now_ext = {{TIME_WIDTH{1'b0}}, req_now};
   assign pub_ext = {32'b0, pub_time_ff};

   // timing compares, registered once per item
   always_comb begin
      el_cycle    = now_ff - cycle_ff;
      el_wake     = now_ff - wake_ff;
      el_last     = now_ff - last_ff;
      warm_end    = {1'b0, cfg.warmup} + {1'b0, cfg.window};
      wake_hit_in = asleep_ff && (CW'(el_cycle) >= CW'(cfg.wake_period));
      warm_el_in  = CW'(el_wake) >= CW'(cfg.warmup);
      end_el_in   = CW'(el_wake) >= CW'(warm_end);
      stale_el_in = CW'(el_last) > CW'(cfg.stale_to);
   end

   // per-item state update
   always_comb begin
      awake       = !asleep_ff || wake_hit_ff;
      warming_cur = wake_hit_ff || warming_ff;
      // right after a wake the elapsed time is zero
      warm_eff    = wake_hit_ff ? (cfg.warmup == '0) : warm_el_ff;
      acc         = awake && !warming_cur && frame_ff && (frames_ff != FRAMES_MAX);
      finish      = awake && !warming_cur && end_el_ff;

      cycle_in    = cycle_ff;
      wake_in     = wake_ff;
      last_in     = last_ff;
      pub_time_in = pub_time_ff;
      asleep_in   = asleep_ff;
      warming_in  = warming_ff;
      valid_in    = valid_ff;
      new_mean_in = new_mean_ff;
      stale_in    = stale_ff;
      count_in    = count_ff;
      frames_in   = frames_ff;
      publish     = 1'b0;

      if (state_ff == ST_APPLY) begin
         frames_in = wake_hit_ff ? '0 : frames_ff + FRAMES_W'(acc);
         publish   = finish && (frames_in != '0);
         if (wake_hit_ff) begin
            cycle_in = now_ff;
            wake_in  = now_ff;
            last_in  = now_ff;
         end
         if (frame_ff) begin
            last_in = now_ff;
         end
         if (awake) begin
            asleep_in  = finish;
            warming_in = warming_cur ? !warm_eff : 1'b0;
         end
         if (publish) begin
            valid_in    = 1'b1;
            pub_time_in = now_ff;
            count_in    = count_ff + COUNT_W'(1);
         end
         new_mean_in = publish;
         stale_in    = !asleep_in && valid_ff && !(frame_ff || wake_hit_ff) && stale_el_ff;
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (state_ff == ST_LOAD) begin
         cnt_in = '0;
      end else if (state_ff == ST_DIV) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CALC;
         ST_CALC:  state_in = ST_APPLY;
         ST_APPLY: state_in = publish ? ST_LOAD : ST_OUT;
         ST_LOAD:  state_in = ST_DIV;
         ST_DIV:   if (cnt_ff == CNT_LAST) state_in = ST_OUT;
         ST_OUT:   if (rsp_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready        = (state_ff == ST_IDLE);
      lane_ctl.capture = accept;
      lane_ctl.clear   = (state_ff == ST_APPLY) && wake_hit_ff;
      lane_ctl.acc     = (state_ff == ST_APPLY) && acc;
      lane_ctl.load    = (state_ff == ST_LOAD);
      lane_ctl.step    = (state_ff == ST_DIV);
      lane_ctl.commit  = (state_ff == ST_DIV) && (cnt_ff == CNT_LAST);
      lane_ctl.divisor = frames_ff;

      status.out_load     = (state_ff == ST_OUT) && rsp_free;
      status.asleep       = asleep_ff;
      status.have_reading = valid_ff;
      status.new_mean     = new_mean_ff;
      status.stale        = stale_ff;
      status.mean_time    = pub_ext[OUT_TIME_W-1:0];
      status.count        = count_ff;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         now_ff   <= now_ext[TIME_WIDTH-1:0];
         frame_ff <= req_frame;
      end
      if (state_ff == ST_CALC) begin
         wake_hit_ff <= wake_hit_in;
         warm_el_ff  <= warm_el_in;
         end_el_ff   <= end_el_in;
         stale_el_ff <= stale_el_in;
      end
      cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         asleep_ff   <= 1'b0;
         warming_ff  <= 1'b1;
         cycle_ff    <= '0;
         wake_ff     <= '0;
         last_ff     <= '0;
         pub_time_ff <= '0;
         valid_ff    <= 1'b0;
         new_mean_ff <= 1'b0;
         stale_ff    <= 1'b0;
         count_ff    <= '0;
         frames_ff   <= '0;
      end else begin
         state_ff    <= state_in;
         asleep_ff   <= asleep_in;
         warming_ff  <= warming_in;
         cycle_ff    <= cycle_in;
         wake_ff     <= wake_in;
         last_ff     <= last_in;
         pub_time_ff <= pub_time_in;
         valid_ff    <= valid_in;
         new_mean_ff <= new_mean_in;
         stale_ff    <= stale_in;
         count_ff    <= count_in;
         frames_ff   <= frames_in;
      end
   end

   a_accept_to_calc: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_CALC))
      else $error("accepted beat did not start the timing compare");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |-> (frames_ff != '0))
      else $error("division started with an empty window");

   a_publish_sleeps: assert property (@(posedge clock) disable iff (reset)
      (status.out_load && new_mean_ff) |-> (asleep_ff && valid_ff))
      else $error("mean published without sleep or valid reading");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |-> (count_ff == $past(count_ff) + COUNT_W'(1)))
      else $error("publication count moved by other than one");

endmodule

>>> rtl/duty_cycled_particle_averager.sv
// Top level of the duty-cycled particle averager: register file, sequencer,
// three averaging lanes and the merged result register.
// Depends on dpa_pkg, dpa_ctrl and dpa_lane.
`timescale 1ns / 1ps

// One input beat per time tick yields exactly one result beat. A beat that
// publishes no new means passes the CALC, APPLY and OUT states before the
// next beat can be accepted; one that publishes new means also passes LOAD and
// the 16-step restoring divider that each of the three lanes (PM1.0, PM2.5,
// PM10) runs in parallel on its window sum. The result has its own register,
// so a new beat is taken while the previous result waits; a further result is
// held back only if that register is still full. Reset leaves the sensor awake
// and warming at time 0. The user must write configuration through the CSR
// port only while the block is idle; the block itself does not enforce it.
module duty_cycled_particle_averager #(
   parameter int TIME_WIDTH = 32
) (
   input  logic         clock,
   input  logic         reset,
   // req_tdata: now_ms[31:0], pm1_raw[47:32], pm25_raw[63:48], pm10_raw[79:64]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [79:0]  req_tdata,
   // req_tuser: frame_present[0]
   input  logic         req_tuser,
   // rsp_tdata: sensor_asleep[0], have_reading[1], pm1_mean[17:2],
   // pm25_mean[33:18], pm10_mean[49:34], mean_time_ms[81:50],
   // means_published[113:82], new_mean[114], stale[115], zero[119:116]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [119:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import dpa_pkg::*;

   cfg_type      cfg_ff;
   csr_idx_type  csr_idx;
   logic         csr_wr;
   lane_ctl_type lane_ctl;
   status_type   status;
   logic         rsp_free;

   logic [RAW_W-1:0] raw_arr  [LANES];
   logic [RAW_W-1:0] mean_arr [LANES];

   logic         rsp_valid_ff;
   logic [119:0] rsp_data_ff;

   // ---------------- configuration registers ----------------
   assign csr_idx    = csr_idx_type'(csr_paddr[3:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wake_period <= WAKE_RST;
         cfg_ff.warmup      <= WARMUP_RST;
         cfg_ff.window      <= WINDOW_RST;
         cfg_ff.stale_to    <= STALE_TO_RST;
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_WAKE_PERIOD: cfg_ff.wake_period <= csr_pwdata[WAKE_W-1:0];
            CSR_WARMUP:      cfg_ff.warmup      <= csr_pwdata[INTERVAL_W-1:0];
            CSR_WINDOW:      cfg_ff.window      <= csr_pwdata[INTERVAL_W-1:0];
            CSR_STALE_TO:    cfg_ff.stale_to    <= csr_pwdata[INTERVAL_W-1:0];
            default:         cfg_ff.stale_to    <= cfg_ff.stale_to;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_WAKE_PERIOD: csr_prdata = 32'(cfg_ff.wake_period);
         CSR_WARMUP:      csr_prdata = 32'(cfg_ff.warmup);
         CSR_WINDOW:      csr_prdata = 32'(cfg_ff.window);
         CSR_STALE_TO:    csr_prdata = 32'(cfg_ff.stale_to);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- sequencer ----------------
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   dpa_ctrl #(
      .TIME_WIDTH (TIME_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_now   (req_tdata[31:0]),
      .req_frame (req_tuser),
      .rsp_free  (rsp_free),
      .lane_ctl  (lane_ctl),
      .status    (status)
   );

   // ---------------- lanes ----------------
   assign raw_arr[0] = req_tdata[47:32];
   assign raw_arr[1] = req_tdata[63:48];
   assign raw_arr[2] = req_tdata[79:64];

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      dpa_lane u_lane (
         .clock (clock),
         .reset (reset),
         .ctl   (lane_ctl),
         .raw   (raw_arr[g]),
         .mean  (mean_arr[g])
      );
   end

   // ---------------- merged result register ----------------
   always_ff @(posedge clock) begin
      if (status.out_load) begin
         rsp_data_ff <= {4'b0, status.stale, status.new_mean, status.count,
                         status.mean_time, mean_arr[2], mean_arr[1], mean_arr[0],
                         status.have_reading, status.asleep};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (status.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

>>> bench/tb_duty_cycled_particle_averager.sv
// Self-checking testbench for duty_cycled_particle_averager: random stream traffic,
// APB timer setup between phases, and a scoreboard with its own duty-cycle model.
// Depends on dpa_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_duty_cycled_particle_averager;
   import dpa_pkg::*;

   localparam int PHASE_ITEMS    = 185;
   localparam int DENSE_FRAMES   = 96;
   localparam int SETTLE_CYCLES  = 32;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [31:0] now_ms;
      logic        frame;
      logic [15:0] pm1_raw;
      logic [15:0] pm25_raw;
      logic [15:0] pm10_raw;
   } tick_t;

   // mirrors rsp_tdata, MSB first
   typedef struct packed {
      logic [3:0]  pad;
      logic        stale;
      logic        new_mean;
      logic [31:0] means_published;
      logic [31:0] mean_time_ms;
      logic [15:0] pm10_mean;
      logic [15:0] pm25_mean;
      logic [15:0] pm1_mean;
      logic        have_reading;
      logic        sensor_asleep;
   } avg_beat_t;

   class averager_scoreboard;
      logic [WAKE_W-1:0]     wake_period;
      logic [INTERVAL_W-1:0] warmup;
      logic [INTERVAL_W-1:0] window;
      logic [INTERVAL_W-1:0] stale_to;
      bit                    asleep;
      bit                    warming;
      bit                    reading_valid;
      logic [31:0]           cycle_start;
      logic [31:0]           wake_time;
      logic [31:0]           last_frame_ms;
      logic [31:0]           sum_pm1, sum_pm25, sum_pm10;
      logic [FRAMES_W-1:0]   frames;
      logic [15:0]           mean_pm1, mean_pm25, mean_pm10;
      logic [31:0]           pub_time;
      logic [31:0]           pub_count;
      avg_beat_t             due_beats[$];
      int                    errors;

      function new();
         wake_period = WAKE_RST;
         warmup = WARMUP_RST;
         window = WINDOW_RST;
         stale_to = STALE_TO_RST;
         asleep = 0;
         warming = 1;
         reading_valid = 0;
         cycle_start = '0;
         wake_time = '0;
         last_frame_ms = '0;
         sum_pm1 = '0;
         sum_pm25 = '0;
         sum_pm10 = '0;
         frames = '0;
         mean_pm1 = '0;
         mean_pm25 = '0;
         mean_pm10 = '0;
         pub_time = '0;
         pub_count = '0;
         errors = 0;
      endfunction

      function void set_register(csr_idx_type idx, logic [31:0] value);
         case (idx)
            CSR_WAKE_PERIOD: wake_period = value[WAKE_W-1:0];
            CSR_WARMUP:      warmup = value[INTERVAL_W-1:0];
            CSR_WINDOW:      window = value[INTERVAL_W-1:0];
            CSR_STALE_TO:    stale_to = value[INTERVAL_W-1:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return due_beats.size();
      endfunction

      function void note_tick(tick_t t);
         logic [31:0] since_start;
         logic [31:0] since_wake;
         logic [31:0] silence;
         logic [32:0] window_end;
         avg_beat_t   r;
         bit          published;
         published = 0;
         // all time differences are kept to 32 bits so they wrap
         since_start = t.now_ms - cycle_start;
         if (asleep && since_start >= 32'(wake_period)) begin
            cycle_start = t.now_ms;
            asleep = 0;
            warming = 1;
            wake_time = t.now_ms;
            last_frame_ms = t.now_ms;
            sum_pm1 = '0;
            sum_pm25 = '0;
            sum_pm10 = '0;
            frames = '0;
         end
         if (t.frame) last_frame_ms = t.now_ms;
         if (!asleep) begin
            since_wake = t.now_ms - wake_time;
            window_end = 33'(warmup) + 33'(window);
            if (warming) begin
               if (since_wake >= 32'(warmup)) warming = 0;
            end else begin
               if (t.frame && frames != FRAMES_MAX) begin
                  sum_pm1 += 32'(t.pm1_raw);
                  sum_pm25 += 32'(t.pm25_raw);
                  sum_pm10 += 32'(t.pm10_raw);
                  frames++;
               end
               if ({1'b0, since_wake} >= window_end) begin
                  if (frames != 0) begin
                     reading_valid = 1;
                     mean_pm1 = 16'(sum_pm1 / 32'(frames));
                     mean_pm25 = 16'(sum_pm25 / 32'(frames));
                     mean_pm10 = 16'(sum_pm10 / 32'(frames));
                     pub_time = t.now_ms;
                     pub_count++;
                     published = 1;
                  end
                  asleep = 1;
               end
            end
         end
         silence = t.now_ms - last_frame_ms;
         r = '0;
         r.sensor_asleep = asleep;
         r.have_reading = reading_valid;
         r.pm1_mean = mean_pm1;
         r.pm25_mean = mean_pm25;
         r.pm10_mean = mean_pm10;
         r.mean_time_ms = pub_time;
         r.means_published = pub_count;
         r.new_mean = published;
         r.stale = !asleep && reading_valid && silence > 32'(stale_to);
         due_beats.push_back(r);
      endfunction

      function void compare(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            errors++;
         end
      endfunction

      function void check_beat(avg_beat_t got);
         avg_beat_t want;
         if (due_beats.size() == 0) begin
            $error("result beat with no prediction pending");
            errors++;
            return;
         end
         want = due_beats.pop_front();
         compare("sensor_asleep", 32'(want.sensor_asleep), 32'(got.sensor_asleep));
         compare("have_reading", 32'(want.have_reading), 32'(got.have_reading));
         compare("pm1_mean", 32'(want.pm1_mean), 32'(got.pm1_mean));
         compare("pm25_mean", 32'(want.pm25_mean), 32'(got.pm25_mean));
         compare("pm10_mean", 32'(want.pm10_mean), 32'(got.pm10_mean));
         compare("mean_time_ms", want.mean_time_ms, got.mean_time_ms);
         compare("means_published", want.means_published, got.means_published);
         compare("new_mean", 32'(want.new_mean), 32'(got.new_mean));
         compare("stale", 32'(want.stale), 32'(got.stale));
      endfunction
   endclass

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [79:0]  req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic         csr_psel = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite = 1'b0;
   logic [3:0]   csr_paddr = '0;
   logic [31:0]  csr_pwdata = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   averager_scoreboard sb;
   bit                 quiet = 0;
   logic [31:0]        tick_ms = '0;
   int                 idle_cycles = 0;

   duty_cycled_particle_averager dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 29);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_beat(avg_beat_t'(rsp_tdata));
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic tick_t mk_tick(logic [31:0] now, logic frame,
                                     logic [15:0] a, logic [15:0] b, logic [15:0] c);
      tick_t t;
      t.now_ms = now;
      t.frame = frame;
      t.pm1_raw = a;
      t.pm25_raw = b;
      t.pm10_raw = c;
      return t;
   endfunction

   function automatic logic [15:0] pick_raw();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_tick(tick_t t);
      if (!quiet) begin
         while ($urandom_range(0, 99) < 29) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {t.pm10_raw, t.pm25_raw, t.pm1_raw, t.now_ms};
      req_tuser <= t.frame;
      do @(posedge clock); while (!req_tready);
      sb.note_tick(t);
      tick_ms = t.now_ms;
   endtask

   // sampled on the falling edge so the check never races the result monitor
   task automatic wait_results_drained();
      @(negedge clock);
      while (sb.pending() != 0) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic load_timers(logic [31:0] wake, logic [31:0] warm,
                              logic [31:0] win, logic [31:0] stale);
      csr_idx_type regs[4];
      logic [31:0] vals[4];
      regs = '{CSR_WAKE_PERIOD, CSR_WARMUP, CSR_WINDOW, CSR_STALE_TO};
      vals = '{wake, warm, win, stale};
      for (int i = 0; i < 4; i++) begin
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {regs[i], 2'b00};
         csr_pwdata <= vals[i];
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
         sb.set_register(regs[i], vals[i]);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic run_phase(logic [31:0] wake, logic [31:0] warm, logic [31:0] win,
                            logic [31:0] stale, int frame_pct);
      logic [31:0] span_wake;
      logic [31:0] span_cycle;
      logic [31:0] dt;
      tick_t       t;
      int          r;
      wait_results_drained();
      quiet = 0;
      load_timers(wake, warm, win, stale);
      span_wake = 32'(sb.wake_period);
      span_cycle = (32'(sb.warmup) + 32'(sb.window)) / 6 + 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
         r = $urandom_range(0, 99);
         if (r < 70) dt = $urandom_range(0, span_cycle);
         else if (r < 85) dt = $urandom_range(0, 2 * 32'(sb.stale_to) + 1);
         else if (r < 97) dt = $urandom_range(span_wake / 2, span_wake + span_wake / 4 + 1);
         else dt = $urandom;
         t = mk_tick(tick_ms + dt, $urandom_range(0, 99) < frame_pct,
                     pick_raw(), pick_raw(), pick_raw());
         send_tick(t);
      end
      req_tvalid <= 1'b0;
   endtask

   // Drives one dense window back to back with no stalls on either side.
   task automatic dense_window();
      tick_t t;
      wait_results_drained();
      quiet = 1;
      load_timers(1, 0, 600000, 600000);
      // two long jumps close whatever window is open and bring a fresh wake
      t = mk_tick(tick_ms + 32'd700000, 1'b0, '0, '0, '0);
      send_tick(t);
      t.now_ms = t.now_ms + 32'd700000;
      send_tick(t);
      t.now_ms = t.now_ms + 32'd1;
      t.frame = 1'b1;
      for (int k = 0; k < DENSE_FRAMES; k++) begin
         t.pm1_raw = pick_raw();
         t.pm25_raw = pick_raw();
         t.pm10_raw = pick_raw();
         send_tick(t);
      end
      t = mk_tick(t.now_ms + 32'd600001, 1'b0, '0, '0, '0);
      send_tick(t);
      req_tvalid <= 1'b0;
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset timers: one full duty cycle, stale, an empty window, then a wrap
      send_tick(mk_tick(32'd0, 1'b1, 16'd1, 16'd2, 16'd3));
      send_tick(mk_tick(32'd29999, 1'b1, 16'd7, 16'd8, 16'd9));
      send_tick(mk_tick(32'd30000, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_tick(mk_tick(32'd30001, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_tick(mk_tick(32'd35000, 1'b1, 16'h0000, 16'h0000, 16'h0000));
      send_tick(mk_tick(32'd39999, 1'b0, 16'h1111, 16'h2222, 16'h3333));
      send_tick(mk_tick(32'd40000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
      send_tick(mk_tick(32'd59999, 1'b1, 16'h4444, 16'h5555, 16'h6666));
      send_tick(mk_tick(32'd60000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
      send_tick(mk_tick(32'd70001, 1'b0, 16'h0000, 16'h0000, 16'h0000));
      send_tick(mk_tick(32'd90000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
      send_tick(mk_tick(32'd100000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
      send_tick(mk_tick(32'hFFFF_FFFF, 1'b1, 16'hAAAA, 16'h5555, 16'h1234));
      send_tick(mk_tick(32'd29999, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
      send_tick(mk_tick(32'd30000, 1'b1, 16'h5555, 16'hAAAA, 16'hFFFF));
      send_tick(mk_tick(32'd35000, 1'b1, 16'h0001, 16'h0002, 16'hFFFE));
      send_tick(mk_tick(32'd40000, 1'b0, 16'h0000, 16'h0000, 16'h0000));
      req_tvalid <= 1'b0;

      run_phase(50, 5, 10, 8, 60);
      run_phase(1, 0, 1, 1, 50);
      run_phase(0, 3, 4, 2, 70);
      run_phase(200, 20, 60, 15, 20);
      run_phase(86400000, 600000, 600000, 600000, 60);
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 50);
      repeat (3) begin
         run_phase($urandom_range(1, 400), $urandom_range(0, 100), $urandom_range(1, 100),
                   $urandom_range(1, 100), $urandom_range(20, 90));
      end
      dense_window();
      run_phase(60000, 30000, 10000, 10000, 60);

      wait_results_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
